### rtl/longest_prefix_match_table_top_assert.svh
// Assertion macros for the longest prefix match table.
`ifndef LONGEST_PREFIX_MATCH_TABLE_TOP_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_TABLE_TOP_ASSERT_SVH

// Check that a condition implies another one in the same cycle.
`define LPMT_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lpmt: assertion failed");

// Check that a condition implies another one in the next cycle.
`define LPMT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lpmt: assertion failed");

`endif

### rtl/lpmt_pkg.sv
// Types, codes and helper functions of the longest prefix match table.
`default_nettype none

package lpmt_pkg;

    localparam int unsigned MAX_PREFIX = 128;
    localparam int unsigned V4_MAX_LEN = 32;
    localparam int unsigned KEY_BITS   = 128;
    localparam int unsigned LEN_BITS   = 8;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_BAD_LEN   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_BAD,
        MODE_DEFAULT,
        MODE_SCAN
    } mode_t;

    typedef struct packed {
        logic                valid;
        logic                family;
        logic [LEN_BITS-1:0] length;
        logic [KEY_BITS-1:0] prefix;
    } slot_t;

    // Mask of the first len bits of a key, most significant bit first.
    function automatic logic [KEY_BITS-1:0] prefix_mask(input logic [LEN_BITS-1:0] len);
        logic [KEY_BITS-1:0] m;
        for (int i = 0; i < KEY_BITS; i++) begin
            m[KEY_BITS-1-i] = (LEN_BITS'(i) < len);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/longest_prefix_match_table_top.sv
// Top level of the longest prefix match table with its slot memory and scan sequencer.
`default_nettype none
`include "longest_prefix_match_table_top_assert.svh"

// Stores IPv4 and IPv6 prefixes with tags in a TABLE_ENTRIES deep slot memory and answers
// lookup, insert and remove transactions one at a time. Lookups and inserts or removes of
// a nonzero, valid prefix length scan the whole memory through its single read port, one
// slot a cycle, then pass through a flush state before the result state, which waits for
// the output register to be free; the next transaction is taken after that. Default tag
// writes, bad lengths and unused kinds skip the scan and go straight to the result state.
// After reset the block runs a clearing pass over every slot of the memory and holds
// s_tready low until it ends. The result sits in an output register, and the next
// transaction is accepted while it waits there.
module longest_prefix_match_table_top #(
    parameter int TABLE_ENTRIES = 64,
    parameter int TAG_BITS      = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // address_high[63:0], address_low[127:64], prefix_len[135:128], tag[167:136]
    input  wire logic [167:0] s_tdata,
    // kind[1:0], is_v6[2]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_tag[31:0]
    output logic [31:0]       m_tdata,
    // matched[0], status[2:1]
    output logic [2:0]        m_tuser
);
    import lpmt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int TAG_W = (TAG_BITS < 32) ? TAG_BITS : 32;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    slot_t            slot_mem [TABLE_ENTRIES];
    logic [TAG_W-1:0] tag_mem  [TABLE_ENTRIES];

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    kind_t               kind_reg, kind_next;
    logic                v6_reg, v6_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    mode_t               mode_reg, mode_next;
    logic                best_valid_reg, best_valid_next;
    logic [LEN_BITS-1:0] best_len_reg, best_len_next;
    logic [TAG_W-1:0]    best_tag_reg, best_tag_next;
    logic                hit_valid_reg, hit_valid_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic                free_valid_reg, free_valid_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [TAG_W-1:0]    default_reg [2];
    logic [TAG_W-1:0]    default_next [2];
    logic                m_tvalid_reg, m_tvalid_next;
    logic [31:0]         m_tdata_reg, m_tdata_next;
    logic                m_matched_reg, m_matched_next;
    status_t             m_status_reg, m_status_next;

    slot_t               rd_slot_reg;
    logic [TAG_W-1:0]    rd_tag_reg;
    logic                rd_en;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    slot_t               wr_slot;
    logic [TAG_W-1:0]    wr_tag;

    kind_t               in_kind;
    logic                in_v6;
    logic [63:0]         in_addr_high;
    logic [63:0]         in_addr_low;
    logic [LEN_BITS-1:0] in_len;
    logic [TAG_W-1:0]    in_tag;
    logic [KEY_BITS-1:0] in_key;
    logic [LEN_BITS-1:0] in_max_len;

    logic                fam_ok;
    logic                lookup_hit;
    logic                exact_hit;
    logic                out_free;

    assign in_kind      = kind_t'(s_tuser[1:0]);
    assign in_v6        = s_tuser[2];
    assign in_addr_high = s_tdata[63:0];
    assign in_addr_low  = s_tdata[127:64];
    assign in_len       = s_tdata[135:128];
    assign in_tag       = s_tdata[136 +: TAG_W];
    assign in_key       = in_v6 ? {in_addr_high, in_addr_low} : {in_addr_low[31:0], 96'd0};
    assign in_max_len   = in_v6 ? LEN_BITS'(MAX_PREFIX) : LEN_BITS'(V4_MAX_LEN);

    assign fam_ok     = rd_slot_reg.valid && (rd_slot_reg.family == v6_reg);
    assign lookup_hit = fam_ok && (rd_slot_reg.length <= LEN_BITS'(MAX_PREFIX)) &&
                        (((key_reg ^ rd_slot_reg.prefix) & prefix_mask(rd_slot_reg.length))
                         == '0);
    assign exact_hit  = fam_ok && (rd_slot_reg.length == len_reg) &&
                        (rd_slot_reg.prefix == key_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        kind_next       = kind_reg;
        v6_next         = v6_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        tag_next        = tag_reg;
        mode_next       = mode_reg;
        best_valid_next = best_valid_reg;
        best_len_next   = best_len_reg;
        best_tag_next   = best_tag_reg;
        hit_valid_next  = hit_valid_reg;
        hit_idx_next    = hit_idx_reg;
        free_valid_next = free_valid_reg;
        free_idx_next   = free_idx_reg;
        default_next    = default_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_matched_next  = m_matched_reg;
        m_status_next   = m_status_reg;
        s_tready        = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_slot         = '0;
        wr_tag          = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cmp_valid_reg) begin
            if (kind_reg == KIND_LOOKUP && lookup_hit &&
                (!best_valid_reg || rd_slot_reg.length > best_len_reg)) begin
                best_valid_next = 1'b1;
                best_len_next   = rd_slot_reg.length;
                best_tag_next   = rd_tag_reg;
            end
            if (exact_hit && !hit_valid_reg) begin
                hit_valid_next = 1'b1;
                hit_idx_next   = cmp_idx_reg;
            end
            if (!rd_slot_reg.valid && !free_valid_reg) begin
                free_valid_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
        end

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    kind_next       = in_kind;
                    v6_next         = in_v6;
                    len_next        = in_len;
                    tag_next        = in_tag;
                    key_next        = in_key;
                    idx_next        = '0;
                    best_valid_next = 1'b0;
                    hit_valid_next  = 1'b0;
                    free_valid_next = 1'b0;
                    unique case (in_kind)
                        KIND_LOOKUP: begin
                            mode_next = MODE_SCAN;
                        end
                        KIND_INSERT, KIND_REMOVE: begin
                            key_next = in_key & prefix_mask(in_len);
                            priority if (in_len > in_max_len) begin
                                mode_next = MODE_BAD;
                            end else if (in_len == '0) begin
                                mode_next = MODE_DEFAULT;
                            end else begin
                                mode_next = MODE_SCAN;
                            end
                        end
                        KIND_NONE: begin
                            mode_next = MODE_NONE;
                        end
                    endcase
                    state_next = ST_DONE;
                    if (in_kind == KIND_LOOKUP ||
                        ((in_kind == KIND_INSERT || in_kind == KIND_REMOVE) &&
                         in_len != '0 && in_len <= in_max_len)) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_en          = 1'b1;
                cmp_valid_next = 1'b1;
                cmp_idx_next   = idx_reg;
                idx_next       = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                cmp_valid_next = 1'b0;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    m_tdata_next   = '0;
                    m_matched_next = 1'b0;
                    m_status_next  = STATUS_OK;
                    state_next     = ST_IDLE;
                    unique case (mode_reg)
                        MODE_NONE: begin
                        end
                        MODE_BAD: begin
                            m_status_next = STATUS_BAD_LEN;
                        end
                        MODE_DEFAULT: begin
                            default_next[v6_reg] = (kind_reg == KIND_INSERT) ? tag_reg : '0;
                        end
                        MODE_SCAN: begin
                            unique case (kind_reg)
                                KIND_LOOKUP: begin
                                    m_tdata_next   = best_valid_reg ? 32'(best_tag_reg)
                                                                    : 32'(default_reg[v6_reg]);
                                    m_matched_next = best_valid_reg;
                                end
                                KIND_INSERT: begin
                                    wr_slot = '{valid: 1'b1, family: v6_reg, length: len_reg,
                                                prefix: key_reg};
                                    wr_tag  = tag_reg;
                                    priority if (hit_valid_reg) begin
                                        wr_en   = 1'b1;
                                        wr_addr = hit_idx_reg;
                                    end else if (free_valid_reg) begin
                                        wr_en   = 1'b1;
                                        wr_addr = free_idx_reg;
                                    end else begin
                                        m_status_next = STATUS_FULL;
                                    end
                                end
                                KIND_REMOVE: begin
                                    if (hit_valid_reg) begin
                                        wr_en   = 1'b1;
                                        wr_addr = hit_idx_reg;
                                    end else begin
                                        m_status_next = STATUS_NOT_FOUND;
                                    end
                                end
                                KIND_NONE: begin
                                end
                            endcase
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            hit_valid_reg  <= 1'b0;
            free_valid_reg <= 1'b0;
            default_reg[0] <= '0;
            default_reg[1] <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            best_valid_reg <= best_valid_next;
            hit_valid_reg  <= hit_valid_next;
            free_valid_reg <= free_valid_next;
            default_reg    <= default_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg   <= cmp_idx_next;
        kind_reg      <= kind_next;
        v6_reg        <= v6_next;
        key_reg       <= key_next;
        len_reg       <= len_next;
        tag_reg       <= tag_next;
        mode_reg      <= mode_next;
        best_len_reg  <= best_len_next;
        best_tag_reg  <= best_tag_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        m_tdata_reg   <= m_tdata_next;
        m_matched_reg <= m_matched_next;
        m_status_reg  <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_slot;
            tag_mem[wr_addr]  <= wr_tag;
        end
        if (rd_en) begin
            rd_slot_reg <= slot_mem[idx_reg];
            rd_tag_reg  <= tag_mem[idx_reg];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = {m_status_reg, m_matched_reg};

    `LPMT_ASSERT_SAME(a_write_only_clear_or_done, wr_en, state_reg == ST_CLEAR || state_reg == ST_DONE)
    `LPMT_ASSERT_SAME(a_done_after_drain, state_reg == ST_DONE, !cmp_valid_reg)
    `LPMT_ASSERT_SAME(a_matched_ok, m_tvalid_reg && m_matched_reg, m_status_reg == STATUS_OK)
    `LPMT_ASSERT_NEXT(a_result_from_done, !m_tvalid_reg && state_reg != ST_DONE, !m_tvalid_reg)

endmodule

`default_nettype wire

### test/tb_longest_prefix_match_table_top.sv
// Self-checking testbench for the longest prefix match table: directed and random transactions.
`timescale 1ns / 100ps

module tb_longest_prefix_match_table_top;
    import lpmt_pkg::*;

    localparam int          TABLE_ENTRIES   = 64;
    localparam int          TAG_BITS        = 32;
    localparam time         CLK_HALF        = 6ns;
    localparam int unsigned ITEMS_PER_PHASE = 405;
    localparam int unsigned ADDRESS_POOL    = 12;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES     = 80;
    localparam int unsigned CYCLE_LIMIT     = 1000000;

    localparam int SENDER_IDLE[4]   = '{0, 50, 0, 14};
    localparam int RECEIVER_STALL[4] = '{0, 0, 50, 14};
    localparam int INSERT_SHARE[4]  = '{60, 35, 15, 35};
    localparam int REMOVE_SHARE[4]  = '{10, 25, 50, 25};

    typedef struct {
        kind_t       kind;
        logic        is_v6;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [7:0]  prefix_len;
        logic [31:0] tag;
    } lpm_request_t;

    typedef struct {
        logic [31:0] result_tag;
        logic        matched;
        status_t     status;
    } lpm_result_t;

    typedef struct {
        lpm_request_t request;
        bit           typed;
        lpm_result_t  answer;
    } directed_row_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata  = '0;
    logic [2:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [2:0]   m_tuser;

    // predictor state
    logic         route_valid[TABLE_ENTRIES];
    logic         route_family[TABLE_ENTRIES];
    logic [127:0] route_prefix[TABLE_ENTRIES];
    logic [7:0]   route_length[TABLE_ENTRIES];
    logic [31:0]  route_tag[TABLE_ENTRIES];
    logic [31:0]  default_route_tag[2];

    lpm_result_t   pending_answers[$];
    directed_row_t directed_rows[$];
    logic [63:0]   pool_high[ADDRESS_POOL];
    logic [63:0]   pool_low[ADDRESS_POOL];

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    logic        pressure_request   = 1'b0;
    int unsigned fail_count         = 0;
    int unsigned cycle_count        = 0;

    longest_prefix_match_table_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .TAG_BITS     (TAG_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [127:0] lead_mask(int unsigned len);
        if (len == 0) begin
            return '0;
        end
        return {128{1'b1}} << (128 - len);
    endfunction

    function automatic logic [127:0] family_key(logic v6, logic [63:0] ah, logic [63:0] al);
        return v6 ? {ah, al} : {al[31:0], 96'd0};
    endfunction

    // Apply one transaction to the predicted table and return its answer.
    function automatic lpm_result_t apply_to_table(lpm_request_t req);
        lpm_result_t  r;
        logic [127:0] key;
        int           best;
        int unsigned  best_len;
        int unsigned  max_len;
        int           hit;
        int           free_slot;
        r.result_tag = '0;
        r.matched    = 1'b0;
        r.status     = STATUS_OK;
        key = family_key(req.is_v6, req.address_high, req.address_low);
        case (req.kind)
            KIND_LOOKUP: begin
                best     = -1;
                best_len = 0;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (route_valid[i] && route_family[i] == req.is_v6 &&
                        (key & lead_mask(route_length[i])) == route_prefix[i] &&
                        (best < 0 || route_length[i] > best_len)) begin
                        best     = i;
                        best_len = route_length[i];
                    end
                end
                if (best >= 0) begin
                    r.result_tag = route_tag[best];
                    r.matched    = 1'b1;
                end else begin
                    r.result_tag = default_route_tag[req.is_v6];
                end
            end
            KIND_INSERT, KIND_REMOVE: begin
                max_len = req.is_v6 ? MAX_PREFIX : V4_MAX_LEN;
                if (req.prefix_len > max_len) begin
                    r.status = STATUS_BAD_LEN;
                end else if (req.prefix_len == 0) begin
                    default_route_tag[req.is_v6] = (req.kind == KIND_INSERT) ? req.tag : '0;
                end else begin
                    key       = key & lead_mask(req.prefix_len);
                    hit       = -1;
                    free_slot = -1;
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (hit < 0 && route_valid[i] && route_family[i] == req.is_v6 &&
                            route_length[i] == req.prefix_len && route_prefix[i] == key) begin
                            hit = i;
                        end
                        if (free_slot < 0 && !route_valid[i]) begin
                            free_slot = i;
                        end
                    end
                    if (req.kind == KIND_REMOVE) begin
                        if (hit >= 0) begin
                            route_valid[hit] = 1'b0;
                        end else begin
                            r.status = STATUS_NOT_FOUND;
                        end
                    end else if (hit >= 0) begin
                        route_tag[hit] = req.tag;
                    end else if (free_slot < 0) begin
                        r.status = STATUS_FULL;
                    end else begin
                        route_valid[free_slot]  = 1'b1;
                        route_family[free_slot] = req.is_v6;
                        route_prefix[free_slot] = key;
                        route_length[free_slot] = req.prefix_len;
                        route_tag[free_slot]    = req.tag;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic lpm_request_t random_request(int unsigned insert_pct,
                                                    int unsigned remove_pct);
        lpm_request_t req;
        int unsigned  pick;
        int unsigned  base;
        int unsigned  max_len;
        logic [63:0]  flip;
        pick = $urandom_range(99);
        if (pick < 3) begin
            req.kind = KIND_NONE;
        end else if (pick < 3 + insert_pct) begin
            req.kind = KIND_INSERT;
        end else if (pick < 3 + insert_pct + remove_pct) begin
            req.kind = KIND_REMOVE;
        end else begin
            req.kind = KIND_LOOKUP;
        end
        req.is_v6 = 1'($urandom_range(1));
        req.tag   = $urandom;
        if ($urandom_range(9) == 0) begin
            req.address_high = {$urandom, $urandom};
            req.address_low  = {$urandom, $urandom};
        end else begin
            base             = $urandom_range(ADDRESS_POOL - 1);
            req.address_high = pool_high[base];
            req.address_low  = pool_low[base];
            flip             = {$urandom, $urandom} >> $urandom_range(63);
            if ($urandom_range(1)) begin
                req.address_low ^= flip;
            end
            if ($urandom_range(4) == 0) begin
                req.address_high ^= flip;
            end
            if (!req.is_v6 && $urandom_range(1)) begin
                req.address_low[63:32] = $urandom;
            end
        end
        max_len = req.is_v6 ? MAX_PREFIX : V4_MAX_LEN;
        pick    = $urandom_range(99);
        if (pick < 5) begin
            req.prefix_len = '0;
        end else if (pick < 10) begin
            req.prefix_len = 8'($urandom_range(255, max_len + 1));
        end else if (pick < 55) begin
            req.prefix_len = req.is_v6 ? 8'(($urandom_range(7) + 1) * 16)
                                       : 8'(($urandom_range(3) + 1) * 8);
        end else begin
            req.prefix_len = 8'($urandom_range(max_len, 1));
        end
        return req;
    endfunction

    function automatic void add_directed(kind_t k, logic v6, logic [63:0] ah, logic [63:0] al,
                                        logic [7:0] len, logic [31:0] tg, bit typed,
                                        logic [31:0] want_tag, logic want_matched,
                                        status_t want_status);
        directed_row_t row;
        row.request.kind         = k;
        row.request.is_v6        = v6;
        row.request.address_high = ah;
        row.request.address_low  = al;
        row.request.prefix_len   = len;
        row.request.tag          = tg;
        row.typed                = typed;
        row.answer.result_tag    = want_tag;
        row.answer.matched       = want_matched;
        row.answer.status        = want_status;
        directed_rows.push_back(row);
    endfunction

    task automatic send_and_predict(lpm_request_t req, bit typed, lpm_result_t typed_answer);
        lpm_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {req.tag, req.prefix_len, req.address_low, req.address_high};
        s_tuser  <= {req.is_v6, req.kind};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_to_table(req);
        pending_answers.push_back(typed ? typed_answer : predicted);
    endtask

    task automatic check_answer();
        lpm_result_t want;
        if (pending_answers.size() == 0) begin
            $error("unexpected result transaction: result_tag %h", m_tdata);
            fail_count++;
        end else begin
            want = pending_answers.pop_front();
            if (m_tdata !== want.result_tag) begin
                $error("result_tag: expected %h, got %h", want.result_tag, m_tdata);
                fail_count++;
            end
            if (m_tuser[0] !== want.matched) begin
                $error("matched: expected %0d, got %0d", want.matched, m_tuser[0]);
                fail_count++;
            end
            if (m_tuser[2:1] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, m_tuser[2:1]);
                fail_count++;
            end
        end
    endtask

    // result side: check, then choose the next tready
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                check_answer();
            end
            if (pressure_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    initial begin
        lpm_result_t  none;
        lpm_request_t req;
        int unsigned  phase;
        int unsigned  n;
        none.result_tag = '0;
        none.matched    = 1'b0;
        none.status     = STATUS_OK;
        for (n = 0; n < TABLE_ENTRIES; n++) begin
            route_valid[n] = 1'b0;
        end
        default_route_tag[0] = '0;
        default_route_tag[1] = '0;
        for (n = 0; n < ADDRESS_POOL; n++) begin
            pool_high[n] = {$urandom, $urandom};
            pool_low[n]  = {$urandom, $urandom};
        end

        add_directed(KIND_LOOKUP, 1'b0, '0, 64'h0A010203, 8'd0, '0, 1,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_LOOKUP, 1'b1, '1, '1, 8'd0, '0, 1,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_REMOVE, 1'b0, '0, 64'h0A000000, 8'd8, '0, 1,
                     '0, 1'b0, STATUS_NOT_FOUND);
        add_directed(KIND_INSERT, 1'b0, '0, 64'h0A000000, 8'd33, 32'h1, 1,
                     '0, 1'b0, STATUS_BAD_LEN);
        add_directed(KIND_INSERT, 1'b1, '1, '1, 8'd129, 32'h1, 1,
                     '0, 1'b0, STATUS_BAD_LEN);
        add_directed(KIND_REMOVE, 1'b1, '1, '1, 8'd255, '0, 1,
                     '0, 1'b0, STATUS_BAD_LEN);
        add_directed(KIND_INSERT, 1'b0, '0, '0, 8'd0, 32'hFFFFFFFF, 1,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_LOOKUP, 1'b0, '0, 64'h01020304, 8'd0, '0, 1,
                     32'hFFFFFFFF, 1'b0, STATUS_OK);
        add_directed(KIND_INSERT, 1'b1, '0, '0, 8'd0, 32'h12345678, 1,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_INSERT, 1'b0, '0, 64'h0AFFFFFF, 8'd8, 32'hA, 1,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_INSERT, 1'b0, '0, 64'h0A010203, 8'd32, 32'h0, 1,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_LOOKUP, 1'b0, '1, 64'hFFFFFFFF_0A010203, 8'd0, '0, 1,
                     32'h0, 1'b1, STATUS_OK);
        add_directed(KIND_LOOKUP, 1'b0, '0, 64'h0A090909, 8'd0, '0, 1,
                     32'hA, 1'b1, STATUS_OK);
        add_directed(KIND_INSERT, 1'b0, '0, 64'h0A000000, 8'd8, 32'hB, 1,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_LOOKUP, 1'b0, '0, 64'h0A090909, 8'd0, '0, 0,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_INSERT, 1'b1, '1, '1, 8'd128, 32'hFFFFFFFF, 1,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_INSERT, 1'b1, 64'h8000000000000000, '0, 8'd1, 32'h5, 1,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_LOOKUP, 1'b1, '1, '1, 8'd0, '0, 0,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_LOOKUP, 1'b1, 64'h8000000000000001, '0, 8'd0, '0, 0,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_LOOKUP, 1'b1, '0, '0, 8'd0, '0, 1,
                     32'h12345678, 1'b0, STATUS_OK);
        add_directed(KIND_NONE, 1'b1, '1, '1, 8'd255, 32'hFFFFFFFF, 1,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_REMOVE, 1'b0, '0, 64'h0A000000, 8'd8, '0, 1,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_LOOKUP, 1'b0, '0, 64'h0A090909, 8'd0, '0, 0,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_REMOVE, 1'b0, '0, '0, 8'd0, '0, 1,
                     '0, 1'b0, STATUS_OK);
        add_directed(KIND_REMOVE, 1'b1, '0, '0, 8'd0, '0, 1,
                     '0, 1'b0, STATUS_OK);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            send_and_predict(directed_rows[r].request, directed_rows[r].typed,
                             directed_rows[r].answer);
        end

        for (phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = SENDER_IDLE[phase];
            receiver_stall_pct = RECEIVER_STALL[phase];
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // stall the result side long enough to back up the input
                if (phase == 0 && n == 60) begin
                    pressure_request <= 1'b1;
                end
                req = random_request(INSERT_SHARE[phase], REMOVE_SHARE[phase]);
                send_and_predict(req, 1'b0, none);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_answers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
